>>> hw/rtl/bdaf_pkg.sv
// Shared types, constants and the double-dabble step for the decimal formatter.
package bdaf_pkg;

	localparam int VALUE_W     = 32;
	localparam int NUM_PLACES  = 5;
	localparam int BCD_W       = 4 * NUM_PLACES;
	localparam int POS_W       = 3;
	localparam int CHAR_W      = 6;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [POS_W-1:0]  POS_TEN_THOUSANDS = 3'd0;
	localparam logic [POS_W-1:0]  POS_THOUSANDS     = 3'd1;
	localparam logic [POS_W-1:0]  POS_HUNDREDS      = 3'd2;
	localparam logic [POS_W-1:0]  POS_TENS          = 3'd3;
	localparam logic [POS_W-1:0]  POS_UNITS         = 3'd4;
	localparam logic [CHAR_W-1:0] DIGIT_ZERO        = 6'd48;

	localparam logic [VALUE_W-1:0] FLOOR_TEN_THOUSANDS = 32'd9999;
	localparam logic [VALUE_W-1:0] FLOOR_THOUSANDS     = 32'd999;
	localparam logic [VALUE_W-1:0] FLOOR_HUNDREDS      = 32'd99;
	localparam logic [VALUE_W-1:0] FLOOR_TENS          = 32'd9;

	// One queue entry: five low decimal digits and the place of the first digit to send.
	typedef struct packed {
		logic [BCD_W-1:0] bcd;
		logic [POS_W-1:0] first;
	} bdaf_item_t;

	// Eight shift-and-correct steps; only the five low BCD digits are kept,
	// which leaves them exact because corrections never flow downward.
	function automatic logic [BCD_W-1:0] dd_step8(input logic [BCD_W-1:0] bcd_in,
	                                               input logic [7:0] bits);
		logic [BCD_W-1:0] acc;
		acc = bcd_in;
		for (int s = 0; s < 8; s++) begin
			for (int n = 0; n < NUM_PLACES; n++) begin
				if (acc[n*4 +: 4] >= 4'd5) begin
					acc[n*4 +: 4] = acc[n*4 +: 4] + 4'd3;
				end
			end
			acc = {acc[BCD_W-2:0], bits[7-s]};
		end
		return acc;
	endfunction

	// Place of the leading digit after zero suppression.
	function automatic logic [POS_W-1:0] first_place(input logic [VALUE_W-1:0] v);
		logic [POS_W-1:0] p;
		if (v > FLOOR_TEN_THOUSANDS) begin
			p = POS_TEN_THOUSANDS;
		end else if (v > FLOOR_THOUSANDS) begin
			p = POS_THOUSANDS;
		end else if (v > FLOOR_HUNDREDS) begin
			p = POS_HUNDREDS;
		end else if (v > FLOOR_TENS) begin
			p = POS_TENS;
		end else begin
			p = POS_UNITS;
		end
		return p;
	endfunction

endpackage

>>> hw/rtl/bdaf_front.sv
// Front end: accept values, classify digit count and convert to BCD in four stages.
module bdaf_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [31:0]            value,
	output logic                   q_valid,
	input  logic                   q_ready,
	output bdaf_pkg::bdaf_item_t   q_item
);
	import bdaf_pkg::*;

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	logic [BCD_W-1:0] bcd_s1, bcd_s2, bcd_s3, bcd_s4;
	logic [23:0]      rem_s1;
	logic [15:0]      rem_s2;
	logic [7:0]       rem_s3;
	logic [POS_W-1:0] first_s1, first_s2, first_s3, first_s4;

	// A stage loads when it is empty or its content moves on.
	assign rdy4     = !vld_s4 || q_ready;
	assign rdy3     = !vld_s3 || rdy4;
	assign rdy2     = !vld_s2 || rdy3;
	assign rdy1     = !vld_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (rdy1) vld_s1 <= in_valid;
			if (rdy2) vld_s2 <= vld_s1;
			if (rdy3) vld_s3 <= vld_s2;
			if (rdy4) vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			bcd_s1   <= dd_step8('0, value[31:24]);
			rem_s1   <= value[23:0];
			first_s1 <= first_place(value);
		end
		if (rdy2) begin
			bcd_s2   <= dd_step8(bcd_s1, rem_s1[23:16]);
			rem_s2   <= rem_s1[15:0];
			first_s2 <= first_s1;
		end
		if (rdy3) begin
			bcd_s3   <= dd_step8(bcd_s2, rem_s2[15:8]);
			rem_s3   <= rem_s2[7:0];
			first_s3 <= first_s2;
		end
		if (rdy4) begin
			bcd_s4   <= dd_step8(bcd_s3, rem_s3);
			first_s4 <= first_s3;
		end
	end

	assign q_valid      = vld_s4;
	assign q_item.bcd   = bcd_s4;
	assign q_item.first = first_s4;

endmodule

>>> hw/rtl/bdaf_fifo.sv
// Short queue between the converter and the character sender.
module bdaf_fifo #(
	parameter int DEPTH = bdaf_pkg::QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_valid,
	output logic                 wr_ready,
	input  bdaf_pkg::bdaf_item_t wr_item,
	output logic                 rd_valid,
	input  logic                 rd_ready,
	output bdaf_pkg::bdaf_item_t rd_item
);
	import bdaf_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	bdaf_item_t       mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             push, pop;

	assign wr_ready = (count_q != CW'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;
	assign rd_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> hw/rtl/bdaf_back.sv
// Back end: send the queued digits one character per beat, units digit last.
module bdaf_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	output logic                 q_ready,
	input  bdaf_pkg::bdaf_item_t q_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [5:0]           digit_char,
	output logic                 last_digit
);
	import bdaf_pkg::*;

	logic             busy_q;
	logic [BCD_W-1:0] bcd_q;
	logic [POS_W-1:0] pos_q;
	logic             at_units, send, load;
	logic [3:0]       nib;

	assign at_units = (pos_q == POS_UNITS);
	assign send     = busy_q && out_ready;
	// Take the next entry when idle or while the units digit leaves.
	assign load     = q_valid && (!busy_q || (send && at_units));
	assign q_ready  = !busy_q || (send && at_units);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q  <= POS_UNITS;
		end else if (load) begin
			busy_q <= 1'b1;
			pos_q  <= q_item.first;
		end else if (send) begin
			if (at_units) begin
				busy_q <= 1'b0;
			end else begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) bcd_q <= q_item.bcd;
	end

	always_comb begin
		case (pos_q)
			POS_TEN_THOUSANDS: nib = bcd_q[19:16];
			POS_THOUSANDS:     nib = bcd_q[15:12];
			POS_HUNDREDS:      nib = bcd_q[11:8];
			POS_TENS:          nib = bcd_q[7:4];
			POS_UNITS:         nib = bcd_q[3:0];
			default:           nib = bcd_q[3:0];
		endcase
	end

	assign out_valid  = busy_q;
	assign digit_char = DIGIT_ZERO + {2'b00, nib};
	assign last_digit = at_units;

endmodule

>>> hw/rtl/binary_to_decimal_ascii_formatter.sv
// Top level of the binary to decimal ASCII formatter.
//
//   Channel | Handshake           | Beat payload
//   --------+---------------------+------------------------------------------
//   in      | in_valid / in_ready | value[31:0], unsigned number
//   out     | out_valid/out_ready | digit_char[5:0] ASCII digit, last_digit
//
// Each value yields one to five characters, one per cycle while out_ready is high,
// most significant first; the output channel therefore limits intake (values of
// 10000 and up give five characters). The four-stage BCD converter takes a
// new value every cycle while stages are free.
// The first character leaves after the four converter stages, the queue and the sender.
// Reset clears pipeline valids, queue pointers and the sender; no clearing pass.
// Stalls on out hold the sender and back up through the queue into the converter.
module binary_to_decimal_ascii_formatter #(
	parameter int QUEUE_DEPTH = bdaf_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [5:0]  digit_char,
	output logic        last_digit
);
	import bdaf_pkg::*;

	// Converter to queue.
	logic       cv_valid, cv_ready;
	bdaf_item_t cv_item;
	// Queue to sender.
	logic       sd_valid, sd_ready;
	bdaf_item_t sd_item;

	// Classify the value and build its five low BCD digits, 8 bits per stage.
	bdaf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.value    (value),
		.q_valid  (cv_valid),
		.q_ready  (cv_ready),
		.q_item   (cv_item)
	);

	// Decouple conversion from the character stream.
	bdaf_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (cv_valid),
		.wr_ready (cv_ready),
		.wr_item  (cv_item),
		.rd_valid (sd_valid),
		.rd_ready (sd_ready),
		.rd_item  (sd_item)
	);

	// Walk the digits from the leading place down to units.
	bdaf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (sd_valid),
		.q_ready    (sd_ready),
		.q_item     (sd_item),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.digit_char (digit_char),
		.last_digit (last_digit)
	);

endmodule
